### hw/rtl/nfws_pkg.sv
package nfws_pkg;

  localparam int SECTOR_COUNT = 20;
  localparam int SECTOR_BYTES = 65536;
  localparam int SECTOR_WORDS = SECTOR_BYTES / 2;
  localparam int TOTAL_WORDS  = SECTOR_COUNT * SECTOR_WORDS;
  localparam int TOTAL_BYTES  = SECTOR_COUNT * SECTOR_BYTES;
  localparam int WORD_AW      = $clog2(TOTAL_WORDS);
  localparam int DATA_W       = 16;
  localparam int ADDR_W       = 21;
  localparam int SECT_W       = 5;

  localparam logic [DATA_W-1:0] ERASED_WORD = '1;

  typedef enum logic [1:0] {
    KIND_READ,
    KIND_WRITE,
    KIND_ERASE_SECTOR,
    KIND_ERASE_ALL
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_RANGE,
    ST_ODD,
    ST_SECTOR
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_CLEAR,
    S_IDLE,
    S_ACCESS,
    S_ERASE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic access;
    logic out_load_fast;
    logic out_load_hold;
    logic walk_start_all;
    logic walk_step;
  } dp_cmd_t;

  typedef struct packed {
    kind_t in_kind;
    logic  in_ok;
    logic  walk_last;
  } dp_stat_t;

endpackage

### hw/rtl/nfws_if.sv
interface nfws_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [nfws_pkg::ADDR_W-1:0]   byte_address;
  logic [nfws_pkg::DATA_W-1:0]   write_data;
  logic [nfws_pkg::SECT_W-1:0]   sector_number;

  modport source (output valid, kind, byte_address, write_data, sector_number, input ready);
  modport sink   (input valid, kind, byte_address, write_data, sector_number, output ready);
endinterface

interface nfws_out_if;
  logic                          valid;
  logic                          ready;
  logic [nfws_pkg::DATA_W-1:0]   read_data;
  logic [1:0]                    status;

  modport source (output valid, read_data, status, input ready);
  modport sink   (input valid, read_data, status, output ready);
endinterface

### hw/rtl/nfws_ram.sv
module nfws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/nfws_dp.sv
module nfws_dp (
  input  logic                          clk,
  input  nfws_pkg::dp_cmd_t             cmd,
  output nfws_pkg::dp_stat_t            stat,
  input  logic [1:0]                    in_kind,
  input  logic [nfws_pkg::ADDR_W-1:0]   in_byte_address,
  input  logic [nfws_pkg::DATA_W-1:0]   in_write_data,
  input  logic [nfws_pkg::SECT_W-1:0]   in_sector_number,
  output logic [nfws_pkg::DATA_W-1:0]   out_read_data,
  output logic [1:0]                    out_status
);

  localparam int AW = nfws_pkg::WORD_AW;

  nfws_pkg::kind_t             kind_in;
  nfws_pkg::status_t           status_in;
  logic [AW-1:0]               base_full;
  logic [AW-1:0]               end_full;
  logic [AW-1:0]               in_word;

  nfws_pkg::kind_t             kind_r;
  nfws_pkg::status_t           status_r;
  logic [AW-1:0]               waddr_r;
  logic [nfws_pkg::DATA_W-1:0] wdata_r;
  logic [nfws_pkg::DATA_W-1:0] hold_r;
  logic [AW-1:0]               walk_addr_r;
  logic [AW-1:0]               walk_end_r;
  logic [nfws_pkg::DATA_W-1:0] out_data_r;
  nfws_pkg::status_t           out_status_r;

  logic                        ram_en;
  logic                        ram_we;
  logic [AW-1:0]               ram_addr;
  logic [nfws_pkg::DATA_W-1:0] ram_wdata;
  logic [nfws_pkg::DATA_W-1:0] ram_rdata;

  assign kind_in = nfws_pkg::kind_t'(in_kind);
  assign in_word = in_byte_address[AW:1];

  always_comb begin
    status_in = nfws_pkg::ST_OK;
    case (kind_in)
      nfws_pkg::KIND_READ, nfws_pkg::KIND_WRITE: begin
        if ({1'b0, in_byte_address} > 22'(nfws_pkg::TOTAL_BYTES - 2)) begin
          status_in = nfws_pkg::ST_RANGE;
        end else if (in_byte_address[0]) begin
          status_in = nfws_pkg::ST_ODD;
        end
      end
      nfws_pkg::KIND_ERASE_SECTOR: begin
        if ({1'b0, in_sector_number} >= 6'(nfws_pkg::SECTOR_COUNT)) begin
          status_in = nfws_pkg::ST_SECTOR;
        end
      end
      default: status_in = nfws_pkg::ST_OK;
    endcase
  end

  assign base_full = AW'(in_sector_number) * AW'(nfws_pkg::SECTOR_WORDS);
  assign end_full  = base_full + AW'(nfws_pkg::SECTOR_WORDS - 1);

  assign stat.in_kind   = kind_in;
  assign stat.in_ok     = (status_in == nfws_pkg::ST_OK);
  assign stat.walk_last = (walk_addr_r == walk_end_r);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r   <= kind_in;
      status_r <= status_in;
      waddr_r  <= in_word;
      wdata_r  <= in_write_data;
      hold_r   <= '0;
      if (kind_in == nfws_pkg::KIND_ERASE_ALL) begin
        walk_addr_r <= '0;
        walk_end_r  <= AW'(nfws_pkg::TOTAL_WORDS - 1);
      end else begin
        walk_addr_r <= base_full;
        walk_end_r  <= end_full;
      end
    end else if (cmd.walk_start_all) begin
      walk_addr_r <= '0;
      walk_end_r  <= AW'(nfws_pkg::TOTAL_WORDS - 1);
    end else if (cmd.walk_step) begin
      walk_addr_r <= walk_addr_r + AW'(1);
    end
    if (cmd.access && kind_r == nfws_pkg::KIND_READ) begin
      hold_r <= ram_rdata;
    end
    if (cmd.out_load_fast) begin
      out_data_r   <= (kind_r == nfws_pkg::KIND_READ) ? ram_rdata : '0;
      out_status_r <= status_r;
    end else if (cmd.out_load_hold) begin
      out_data_r   <= hold_r;
      out_status_r <= status_r;
    end
  end

  always_comb begin
    ram_we    = cmd.walk_step || (cmd.access && kind_r == nfws_pkg::KIND_WRITE);
    ram_en    = ram_we || (cmd.accept && stat.in_ok &&
                (kind_in == nfws_pkg::KIND_READ || kind_in == nfws_pkg::KIND_WRITE));
    ram_wdata = cmd.walk_step ? nfws_pkg::ERASED_WORD : (ram_rdata & wdata_r);
    if (cmd.walk_step) begin
      ram_addr = walk_addr_r;
    end else if (cmd.access) begin
      ram_addr = waddr_r;
    end else begin
      ram_addr = in_word;
    end
  end

  nfws_ram #(
    .WIDTH (nfws_pkg::DATA_W),
    .DEPTH (nfws_pkg::TOTAL_WORDS)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_read_data = out_data_r;
  assign out_status    = out_status_r;

endmodule

### hw/rtl/nfws_ctrl.sv
module nfws_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  nfws_pkg::dp_stat_t stat,
  output nfws_pkg::dp_cmd_t  cmd
);

  nfws_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nfws_pkg::S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nfws_pkg::S_INIT:  state_nxt = nfws_pkg::S_CLEAR;
      nfws_pkg::S_CLEAR: begin
        if (stat.walk_last) state_nxt = nfws_pkg::S_IDLE;
      end
      nfws_pkg::S_IDLE: begin
        if (in_valid) begin
          if (!stat.in_ok) begin
            state_nxt = nfws_pkg::S_DONE;
          end else if (stat.in_kind == nfws_pkg::KIND_READ ||
                       stat.in_kind == nfws_pkg::KIND_WRITE) begin
            state_nxt = nfws_pkg::S_ACCESS;
          end else begin
            state_nxt = nfws_pkg::S_ERASE;
          end
        end
      end
      nfws_pkg::S_ACCESS: state_nxt = slot_free ? nfws_pkg::S_IDLE : nfws_pkg::S_DONE;
      nfws_pkg::S_ERASE: begin
        if (stat.walk_last) state_nxt = nfws_pkg::S_DONE;
      end
      nfws_pkg::S_DONE: begin
        if (slot_free) state_nxt = nfws_pkg::S_IDLE;
      end
      default: state_nxt = nfws_pkg::S_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      nfws_pkg::S_INIT:  cmd.walk_start_all = 1'b1;
      nfws_pkg::S_CLEAR: cmd.walk_step = 1'b1;
      nfws_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      nfws_pkg::S_ACCESS: begin
        cmd.access        = 1'b1;
        cmd.out_load_fast = slot_free;
      end
      nfws_pkg::S_ERASE: cmd.walk_step = 1'b1;
      nfws_pkg::S_DONE:  cmd.out_load_hold = slot_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.out_load_fast || cmd.out_load_hold) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hw/rtl/nor_flash_word_store_top.sv
// NOR flash word store: 20 sectors of 64 KiB held as 655360 words of 16 bits.
// in_req carries one operation per transaction (read word, program word,
// erase sector, erase all); out_rsp returns exactly one transaction per
// operation with the word read and a status code, in order.
// Read and program: the single-port array does the read when the operation is
// accepted and the masked write-back in the ACCESS state, where the result
// register is loaded when out_rsp is free. A new operation is accepted only
// after the result is loaded, so operations do not overlap.
// Rejected operations pass through the DONE state and change nothing.
// Erase sector walks the sector one word a cycle, all 32768 words.
// Erase all walks the whole array of 655360 words.
// After reset the block clears the array in one pass with in_req.ready low;
// the array then reads as all ones.
// When the receiver stalls, the result holds in the output register; one more
// operation may be accepted and run, then waits for the slot to free.
module nor_flash_word_store_top (
  input logic        clk,
  input logic        rst_n,
  nfws_in_if.sink    in_req,
  nfws_out_if.source out_rsp
);

  nfws_pkg::dp_cmd_t  cmd;
  nfws_pkg::dp_stat_t stat;

  nfws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  nfws_dp u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .stat             (stat),
    .in_kind          (in_req.kind),
    .in_byte_address  (in_req.byte_address),
    .in_write_data    (in_req.write_data),
    .in_sector_number (in_req.sector_number),
    .out_read_data    (out_rsp.read_data),
    .out_status       (out_rsp.status)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("second transaction accepted while busy");

  a_reject_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.status != nfws_pkg::ST_OK) |-> (out_rsp.read_data == '0))
    else $error("rejected operation returned data");

  a_walk_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step |-> !(cmd.accept || cmd.access))
    else $error("erase walk overlaps array access");
`endif

endmodule
